>>> rtl/cfb_pkg.sv
`timescale 1ns / 1ps

package cfb_pkg;

  localparam logic [7:0]  PREAMBLE = 8'hE3;
  // low 24 bits of 0x1864CFB; bit 24 is implied by the shift out of bit 23
  localparam logic [23:0] CRC_POLY = 24'h864CFB;
  localparam logic [23:0] CRC_INIT = 24'h000000;
  localparam logic [15:0] SRC_ID_RESET = 16'h0001;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  // one classified input transaction, handed from front to back
  typedef struct packed {
    logic [7:0]  data;
    logic [15:0] len;
    logic [15:0] sid;
    logic        first;
    logic        last;
  } cmd_t;

  function automatic logic [23:0] crc_feed(logic [23:0] crc, logic [7:0] b);
    logic [23:0] c;
    c = crc ^ {b, 16'h0000};
    for (int i = 0; i < 8; i++) begin
      c = c[23] ? ({c[22:0], 1'b0} ^ CRC_POLY) : {c[22:0], 1'b0};
    end
    return c;
  endfunction

endpackage

>>> rtl/crc24q_frame_builder_top.sv
`timescale 1ns / 1ps

// CRC-24Q frame builder.
// Input channel (push/full): one payload byte per transaction with frame_length
// (sampled on a frame's first byte) and last_byte. Output channel (empty/pop):
// the framed byte stream: preamble, 16-bit length, 16-bit source id, payload,
// then three CRC-24Q bytes; run_last marks the final byte caused by an input
// transaction, frame_end marks the final CRC byte.
// The source id is written through src_id_we_i/src_id_i; it is captured with
// the first byte of each frame.
// A byte pushed into an idle block is written into the command queue, then
// registered into the output byte. Throughput: one output byte per cycle while
// pop keeps up and a command waits, set by the single-byte output sequencer.
// A middle byte yields its data byte alone; a first byte adds the five header
// bytes, a last byte the three CRC bytes. A four-entry command queue sits
// between the input side and the sequencer, so input keeps flowing while the
// header or CRC bytes drain. Reset clears the queue, the frame state and the
// output valid flag and sets the source id to 1. When pop stays low the
// output byte holds, the sequencer stops and full rises once the queue fills.
module crc24q_frame_builder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte_i,
  input  logic [15:0] frame_length_i,
  input  logic        last_byte_i,
  input  logic        src_id_we_i,
  input  logic [15:0] src_id_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte_o,
  output logic        run_last_o,
  output logic        frame_end_o
);

  cfb_pkg::cmd_t push_cmd, head_cmd;
  logic          q_push, q_full, q_pop, q_empty;

  cfb_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .data_byte_i    (data_byte_i),
    .frame_length_i (frame_length_i),
    .last_byte_i    (last_byte_i),
    .src_id_we_i    (src_id_we_i),
    .src_id_i       (src_id_i),
    .q_push_o       (q_push),
    .q_cmd_o        (push_cmd),
    .q_full_i       (q_full)
  );

  cfb_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .head_o     (head_cmd),
    .empty_o    (q_empty)
  );

  cfb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head_cmd),
    .q_empty_i   (q_empty),
    .q_pop_o     (q_pop),
    .empty       (empty),
    .pop         (pop),
    .out_byte_o  (out_byte_o),
    .run_last_o  (run_last_o),
    .frame_end_o (frame_end_o)
  );

endmodule

>>> rtl/cfb_front.sv
`timescale 1ns / 1ps

module cfb_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push,
  output logic            full,
  input  logic [7:0]      data_byte_i,
  input  logic [15:0]     frame_length_i,
  input  logic            last_byte_i,
  input  logic            src_id_we_i,
  input  logic [15:0]     src_id_i,
  output logic            q_push_o,
  output cfb_pkg::cmd_t   q_cmd_o,
  input  logic            q_full_i
);

  logic        inside_frame_q, inside_frame_d;
  logic [15:0] src_id_q;
  logic        accept;

  assign full   = q_full_i;
  assign accept = push && !q_full_i;

  always_comb begin
    q_cmd_o.data  = data_byte_i;
    q_cmd_o.len   = frame_length_i;
    q_cmd_o.sid   = src_id_q;
    q_cmd_o.first = !inside_frame_q;
    q_cmd_o.last  = last_byte_i;
  end

  assign q_push_o = accept;

  always_comb begin
    inside_frame_d = inside_frame_q;
    if (accept) begin
      inside_frame_d = !last_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_frame_q <= 1'b0;
      src_id_q       <= cfb_pkg::SRC_ID_RESET;
    end else begin
      inside_frame_q <= inside_frame_d;
      if (src_id_we_i) begin
        src_id_q <= src_id_i;
      end
    end
  end

endmodule

>>> rtl/cfb_queue.sv
`timescale 1ns / 1ps

module cfb_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  cfb_pkg::cmd_t   push_cmd_i,
  output logic            full_o,
  input  logic            pop_i,
  output cfb_pkg::cmd_t   head_o,
  output logic            empty_o
);

  cfb_pkg::cmd_t               entry_q [cfb_pkg::QDEPTH];
  logic [cfb_pkg::QAW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [cfb_pkg::QAW:0]       count_q, count_d;
  logic                        do_push, do_pop;

  assign full_o  = (count_q == (cfb_pkg::QAW+1)'(cfb_pkg::QDEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = entry_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

>>> rtl/cfb_back.sv
`timescale 1ns / 1ps

module cfb_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cfb_pkg::cmd_t   head_i,
  input  logic            q_empty_i,
  output logic            q_pop_o,
  output logic            empty,
  input  logic            pop,
  output logic [7:0]      out_byte_o,
  output logic            run_last_o,
  output logic            frame_end_o
);

  localparam logic [3:0] S_PRE  = 4'd0;
  localparam logic [3:0] S_LENH = 4'd1;
  localparam logic [3:0] S_LENL = 4'd2;
  localparam logic [3:0] S_SIDH = 4'd3;
  localparam logic [3:0] S_SIDL = 4'd4;
  localparam logic [3:0] S_DATA = 4'd5;
  localparam logic [3:0] S_CRC2 = 4'd6;
  localparam logic [3:0] S_CRC1 = 4'd7;
  localparam logic [3:0] S_CRC0 = 4'd8;

  logic        active_q, active_d;
  logic [3:0]  step_q, step_d, cur_step, next_step;
  logic [23:0] crc_q, crc_d, crc_base;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  out_byte_q, cur_byte;
  logic        run_last_q, frame_end_q;
  logic        emit, final_step, feeds_crc;

  // mid-item the step is held; a fresh item starts at the header or at its data byte
  assign cur_step = active_q ? step_q : (head_i.first ? S_PRE : S_DATA);
  assign emit     = !q_empty_i && (!out_valid_q || pop);

  always_comb begin
    cur_byte  = head_i.data;
    next_step = S_DATA;
    feeds_crc = 1'b1;
    unique case (cur_step)
      S_PRE: begin
        cur_byte  = cfb_pkg::PREAMBLE;
        next_step = S_LENH;
      end
      S_LENH: begin
        cur_byte  = head_i.len[15:8];
        next_step = S_LENL;
      end
      S_LENL: begin
        cur_byte  = head_i.len[7:0];
        next_step = S_SIDH;
      end
      S_SIDH: begin
        cur_byte  = head_i.sid[15:8];
        next_step = S_SIDL;
      end
      S_SIDL: begin
        cur_byte  = head_i.sid[7:0];
        next_step = S_DATA;
      end
      S_DATA: begin
        cur_byte  = head_i.data;
        next_step = S_CRC2;
      end
      S_CRC2: begin
        cur_byte  = crc_q[23:16];
        next_step = S_CRC1;
        feeds_crc = 1'b0;
      end
      S_CRC1: begin
        cur_byte  = crc_q[15:8];
        next_step = S_CRC0;
        feeds_crc = 1'b0;
      end
      S_CRC0: begin
        cur_byte  = crc_q[7:0];
        next_step = S_PRE;
        feeds_crc = 1'b0;
      end
      default: begin
        cur_byte  = head_i.data;
        next_step = S_DATA;
        feeds_crc = 1'b0;
      end
    endcase
  end

  assign final_step = ((cur_step == S_DATA) && !head_i.last) || (cur_step == S_CRC0);
  assign q_pop_o    = emit && final_step;
  assign crc_base   = (cur_step == S_PRE) ? cfb_pkg::CRC_INIT : crc_q;

  always_comb begin
    active_d    = active_q;
    step_d      = step_q;
    crc_d       = crc_q;
    out_valid_d = out_valid_q;
    if (pop) begin
      out_valid_d = 1'b0;
    end
    if (emit) begin
      out_valid_d = 1'b1;
      active_d    = !final_step;
      step_d      = next_step;
      if (feeds_crc) begin
        crc_d = cfb_pkg::crc_feed(crc_base, cur_byte);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      step_q      <= S_PRE;
      crc_q       <= cfb_pkg::CRC_INIT;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      step_q      <= step_d;
      crc_q       <= crc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_byte_q  <= cur_byte;
      run_last_q  <= final_step;
      frame_end_q <= (cur_step == S_CRC0);
    end
  end

  assign empty       = !out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign run_last_o  = run_last_q;
  assign frame_end_o = frame_end_q;

`ifndef SYNTHESIS
  a_frame_end_is_run_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && frame_end_q |-> run_last_q)
    else $error("frame end without run_last");

  a_active_has_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> !q_empty_i)
    else $error("item in progress but queue empty");

  a_active_not_pre: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (step_q != S_PRE))
    else $error("preamble step while mid-item");

  a_pop_after_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> !active_q)
    else $error("item retired but sequencer still active");
`endif

endmodule
